/* hw/rtl/svt_pkg.sv */
`default_nettype none

package svt_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 64;
  localparam int DATA_WIDTH  = 32;

  // Fixed port widths
  localparam int IN_DATA_W   = 32;
  localparam int POS_W       = 10;
  localparam int COUNT_OUT_W = 11;
  localparam int STATUS_W    = 2;
  localparam int OPC_W       = 2;

  // Occupancy counter and comparison widths
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // Request opcodes
  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPC_W-1:0] OP_DEDUP  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_POS = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic ins;
    logic del;
    logic dd_start;
    logic dd_step;
    logic res_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic dd_done;
  } dp_stat_t;

  // Sign-extend or wrap an incoming value to the stored width
  function automatic data_t wrap_in(logic signed [IN_DATA_W-1:0] v);
    return DATA_WIDTH'(v);
  endfunction

  // Sign-extend or wrap a stored value to the result width
  function automatic logic signed [IN_DATA_W-1:0] to_out(data_t d);
    return IN_DATA_W'(d);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sorted_value_table_unit.sv */
// Insert, delete and unknown opcodes: result valid in the cycle after accept; one request
// per cycle while results are taken. Remove-duplicates: a cursor scan over the cell row, then
// the result; no request is taken during the scan. Reset (synchronous, rst_n low) empties the
// table and drops any pending result; cell contents are not cleared and need no clearing pass.
`default_nettype none

module sorted_value_table_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [svt_pkg::OPC_W-1:0]            in_opcode,
  input  wire logic signed [svt_pkg::IN_DATA_W-1:0] in_value,
  input  wire logic [svt_pkg::POS_W-1:0]            in_position,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [svt_pkg::STATUS_W-1:0]              out_status,
  output logic signed [svt_pkg::IN_DATA_W-1:0]      out_removed_value,
  output logic [svt_pkg::COUNT_OUT_W-1:0]           out_entry_count
);
  import svt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence requests
  svt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the sorted cells and the result register
  svt_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_value          (in_value),
    .in_position       (in_position),
    .stat              (stat),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count)
  );

endmodule

`default_nettype wire

/* hw/rtl/svt_datapath.sv */
`default_nettype none

module svt_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire svt_pkg::dp_cmd_t                     cmd,
  input  wire logic signed [svt_pkg::IN_DATA_W-1:0] in_value,
  input  wire logic [svt_pkg::POS_W-1:0]            in_position,
  output svt_pkg::dp_stat_t                         stat,
  output logic [svt_pkg::STATUS_W-1:0]              out_status,
  output logic signed [svt_pkg::IN_DATA_W-1:0]      out_removed_value,
  output logic [svt_pkg::COUNT_OUT_W-1:0]           out_entry_count
);
  import svt_pkg::*;

  data_t                     entries_r   [MAX_ENTRIES];
  data_t                     entries_nxt [MAX_ENTRIES];
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [MAX_ENTRIES-1:0]    ge_r;
  logic [MAX_ENTRIES-1:0]    ge_nxt;

  logic [MAX_ENTRIES-1:0]    valid;
  logic [MAX_ENTRIES-1:0]    lt;
  logic [MAX_ENTRIES-1:0]    eq;
  logic [MAX_ENTRIES-1:0]    cur;
  logic [MAX_ENTRIES-1:0]    del_sel;
  logic [MAX_ENTRIES-1:0]    del_mask;
  logic [MAX_ENTRIES-1:0]    shift_mask;

  data_t                     x;
  data_t                     sel_val;
  logic                      full;
  logic                      pos_ok;
  logic                      dup;
  logic                      do_ins;
  logic                      do_del;
  logic                      do_dd;
  logic                      do_shl;

  logic [STATUS_W-1:0]       status_r;
  logic signed [IN_DATA_W-1:0] removed_r;
  logic [COUNT_OUT_W-1:0]    count_out_r;

  assign x      = wrap_in(in_value);
  assign full   = (count_r == CNT_W'(MAX_ENTRIES));
  assign pos_ok = (in_position != '0) && (CMP_W'(in_position) <= CMP_W'(count_r));

  // Per-cell flags: occupancy, order against the new value, delete position
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid[i]    = (CMP_W'(i) < CMP_W'(count_r));
      lt[i]       = valid[i] && (entries_r[i] < x);
      del_sel[i]  = (CMP_W'(in_position) == CMP_W'(i + 1));
      del_mask[i] = (CMP_W'(in_position) <= CMP_W'(i + 1));
    end
  end

  // Neighbour equality and the deduplication cursor
  always_comb begin
    eq[0]  = 1'b0;
    cur[0] = ge_r[0];
    for (int i = 1; i < MAX_ENTRIES; i++) begin
      eq[i]  = (entries_r[i] == entries_r[i-1]);
      cur[i] = ge_r[i] & ~ge_r[i-1];
    end
  end

  assign dup          = |(cur & eq & valid);
  assign stat.dd_done = ~|(ge_r & valid);

  // Pick the entry that a delete removes
  always_comb begin
    sel_val = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      sel_val = sel_val | (entries_r[i] & {DATA_WIDTH{del_sel[i]}});
    end
  end

  assign do_ins     = cmd.ins & ~full;
  assign do_del     = cmd.del & pos_ok;
  assign do_dd      = cmd.dd_step & dup;
  assign do_shl     = do_del | do_dd;
  assign shift_mask = do_del ? del_mask : ge_r;

  // Shift cells right to open a slot, or left to close one
  always_comb begin
    entries_nxt = entries_r;
    if (do_ins) begin
      if (!lt[0]) begin
        entries_nxt[0] = x;
      end
      for (int i = 1; i < MAX_ENTRIES; i++) begin
        if (!lt[i]) begin
          entries_nxt[i] = lt[i-1] ? x : entries_r[i-1];
        end
      end
    end else if (do_shl) begin
      for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
        if (shift_mask[i]) begin
          entries_nxt[i] = entries_r[i+1];
        end
      end
    end
  end

  // Track the count of held entries
  always_comb begin
    priority if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_shl) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // Start the cursor at the second entry; advance it past distinct values
  always_comb begin
    priority if (cmd.dd_start) begin
      ge_nxt = {{(MAX_ENTRIES-1){1'b1}}, 1'b0};
    end else if (cmd.dd_step && !dup) begin
      ge_nxt = {ge_r[MAX_ENTRIES-2:0], 1'b0};
    end else begin
      ge_nxt = ge_r;
    end
  end

  always_ff @(posedge clk) begin
    entries_r <= entries_nxt;
    ge_r      <= ge_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Capture the result of the finished request
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (cmd.ins && full) begin
        status_r <= STAT_FULL;
      end else if (cmd.del && !pos_ok) begin
        status_r <= STAT_BAD_POS;
      end else begin
        status_r <= STAT_OK;
      end
      removed_r   <= do_del ? to_out(sel_val) : '0;
      count_out_r <= COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_entry_count   = count_out_r;

endmodule

`default_nettype wire

/* hw/rtl/svt_ctrl.sv */
`default_nettype none

module svt_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [svt_pkg::OPC_W-1:0] in_opcode,
  output logic                          in_stall,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  input  wire svt_pkg::dp_stat_t        stat,
  output svt_pkg::dp_cmd_t              cmd
);
  import svt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DEDUP = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;
  logic   go;

  assign slot_free = ~out_valid_r | ~out_stall;
  assign in_stall  = ~((state_r == ST_IDLE) & slot_free);
  assign go        = in_valid & ~in_stall;

  // Decode requests and sequence the deduplication pass
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          cmd.ins = (in_opcode == OP_INSERT);
          cmd.del = (in_opcode == OP_DELETE);
          if (in_opcode == OP_DEDUP) begin
            cmd.dd_start = 1'b1;
            state_nxt    = ST_DEDUP;
          end else begin
            cmd.res_load = 1'b1;
          end
        end
      end
      ST_DEDUP: begin
        if (stat.dd_done) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.dd_step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    priority if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* tb/sorted_value_table_unit_tb.sv */
`timescale 1ns / 100ps

module sorted_value_table_unit_tb;
  import svt_pkg::*;

  // Unused opcode: the block must treat it as a no-op
  localparam logic [OPC_W-1:0] OP_NOP = 2'd3;

  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = MAX_ENTRIES + 16;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 7;

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_mode_t;

  typedef struct {
    logic [STATUS_W-1:0]         status;
    logic signed [IN_DATA_W-1:0] removed;
    logic [COUNT_OUT_W-1:0]      count;
  } table_result_t;

  // Shadow of the sorted table plus the queue of results still owed
  class table_scoreboard;
    data_t         entries[MAX_ENTRIES];
    int            held;
    int            errors;
    int            n_insert, n_full, n_delete, n_bad_pos, n_dedup, n_nop, n_checked;
    table_result_t expected_q[$];

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request to the shadow table and queue its result
    function void note_request(logic [OPC_W-1:0] op, logic signed [IN_DATA_W-1:0] val,
                               logic [POS_W-1:0] pos);
      table_result_t r;
      data_t         x;
      int            at;
      int            keep;
      r.status  = STAT_OK;
      r.removed = '0;
      case (op)
        OP_INSERT: begin
          n_insert++;
          x = DATA_WIDTH'(val);
          if (held >= MAX_ENTRIES) begin
            r.status = STAT_FULL;
            n_full++;
          end else begin
            // Go in front of the first entry that is not smaller
            at = 0;
            while (at < held && entries[at] < x) at++;
            for (int i = held; i > at; i--) entries[i] = entries[i-1];
            entries[at] = x;
            held++;
          end
        end
        OP_DELETE: begin
          n_delete++;
          if (pos == 0 || int'(pos) > held) begin
            r.status = STAT_BAD_POS;
            n_bad_pos++;
          end else begin
            r.removed = IN_DATA_W'(entries[pos-1]);
            for (int i = pos - 1; i + 1 < held; i++) entries[i] = entries[i+1];
            held--;
          end
        end
        OP_DEDUP: begin
          n_dedup++;
          // Keep the first of each run of equal neighbours
          if (held > 1) begin
            keep = 1;
            for (int i = 1; i < held; i++) begin
              if (entries[i] != entries[keep-1]) begin
                entries[keep] = entries[i];
                keep++;
              end
            end
            held = keep;
          end
        end
        default: n_nop++;
      endcase
      r.count = COUNT_OUT_W'(held);
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted result against the oldest one owed
    task check_result(logic [STATUS_W-1:0] status, logic signed [IN_DATA_W-1:0] removed,
                      logic [COUNT_OUT_W-1:0] count);
      table_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result, status %0d count %0d", status, count));
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (status !== want.status)
          report($sformatf("status got %0d want %0d", status, want.status));
        if (removed !== want.removed)
          report($sformatf("removed_value got %0d want %0d", removed, want.removed));
        if (count !== want.count)
          report($sformatf("entry_count got %0d want %0d", count, want.count));
      end
    endtask
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [OPC_W-1:0]            in_opcode;
  logic signed [IN_DATA_W-1:0] in_value;
  logic [POS_W-1:0]            in_position;
  logic                        out_valid;
  logic                        out_stall;
  logic [STATUS_W-1:0]         out_status;
  logic signed [IN_DATA_W-1:0] out_removed_value;
  logic [COUNT_OUT_W-1:0]      out_entry_count;

  table_scoreboard sb = new();
  bit              idle_on;
  bit              hold_out;
  int              quiet_count;

  sorted_value_table_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Check every result taken by the receiver
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_removed_value, out_entry_count);
  end

  // End the run when neither side has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else if (quiet_count >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results owed", quiet_count,
               sb.pending());
      $display("status: fail");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Receiver: stall in random bursts, twice for a long stretch
  initial begin : result_side
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request, optionally after a gap, and hold it until taken
  task automatic send_request(logic [OPC_W-1:0] op, logic signed [IN_DATA_W-1:0] val,
                              logic [POS_W-1:0] pos, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_value    <= val;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, val, pos);
  endtask

  // Drop valid and hold until every owed result has arrived
  task automatic wait_settled();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    send_request(OP_DEDUP, 32'sd0, 10'd0, 0);             // dedup on an empty table
    send_request(OP_DELETE, 32'sd0, 10'd1, 0);            // delete from an empty table
    send_request(OP_NOP, 32'sd7, 10'd3, 0);
    send_request(OP_INSERT, 32'sd5, 10'd0, 0);
    send_request(OP_DEDUP, 32'sd0, 10'd0, 0);             // dedup with one entry
    send_request(OP_INSERT, 32'h7fffffff, 10'd0, 0);
    send_request(OP_INSERT, 32'h80000000, 10'd0, 0);
    send_request(OP_INSERT, -32'sd1, 10'd0, 0);
    send_request(OP_INSERT, 32'sd0, 10'd0, 0);
    send_request(OP_INSERT, 32'sd5, 10'h3ff, 0);          // equal value goes in front
    send_request(OP_INSERT, 32'sd5, 10'd0, 0);
    send_request(OP_INSERT, 32'h7fffffff, 10'd0, 0);
    send_request(OP_INSERT, 32'h55555555, 10'd0, 0);
    send_request(OP_INSERT, 32'haaaaaaaa, 10'd0, 0);
    send_request(OP_DELETE, 32'sd0, 10'h3ff, 0);          // far beyond the count
    send_request(OP_DELETE, 32'sd0, 10'd0, 0);            // position zero
    send_request(OP_DELETE, 32'sd0, 10'h2aa, 0);
    send_request(OP_DELETE, 32'sd0, 10'h155, 0);
    send_request(OP_DELETE, 32'sd0, POS_W'(sb.held + 1), 0);
    send_request(OP_DEDUP, 32'sd0, 10'd0, 0);
    send_request(OP_DELETE, 32'sd0, POS_W'(sb.held), 0);  // last entry
    send_request(OP_DELETE, 32'sd0, 10'd1, 0);            // first entry
    send_request(OP_DELETE, 32'sd0, 10'd2, 0);
    send_request(OP_NOP, -32'sd1, 10'h3ff, 0);
  endtask

  // Pick and send one random request, weighted by the phase's mix
  task automatic run_random_item(mix_mode_t mode);
    int                          roll;
    int                          ins_pct;
    int                          del_pct;
    int                          gap;
    logic [OPC_W-1:0]            op;
    logic signed [IN_DATA_W-1:0] val;
    logic [POS_W-1:0]            pos;
    case (mode)
      MODE_FILL: begin
        ins_pct = 82;
        del_pct = 10;
      end
      MODE_DRAIN: begin
        ins_pct = 25;
        del_pct = 68;
      end
      default: begin
        ins_pct = 50;
        del_pct = 42;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) op = OP_INSERT;
    else if (roll < ins_pct + del_pct) op = OP_DELETE;
    else if (roll < 97) op = OP_DEDUP;
    else op = OP_NOP;

    // Often a narrow range so that duplicates pile up
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      val = int'($urandom_range(0, 8)) - 4;
    end else if (roll < 8) begin
      val = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: val = 32'h7fffffff;
        1: val = 32'h80000000;
        2: val = -32'sd1;
        default: val = 32'sd0;
      endcase
    end

    roll = $urandom_range(0, 9);
    if (sb.held > 0 && roll < 7) pos = POS_W'($urandom_range(1, sb.held));
    else if (roll == 7) pos = '0;
    else if (roll == 8) pos = POS_W'(sb.held + 1);
    else pos = POS_W'($urandom);

    gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
    send_request(op, val, pos, gap);
  endtask

  initial begin : request_side
    mix_mode_t plan[NUM_PHASES];
    plan = '{MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_FILL, MODE_MIXED, MODE_DRAIN, MODE_FILL};
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_INSERT;
    in_value    <= '0;
    in_position <= '0;
    idle_on  = 1'b0;
    hold_out = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_settled();

    // Random phases; the last one runs with no idling on either side
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_on = (ph < NUM_PHASES - 1);
      if (ph == 1 || ph == 3) hold_out = 1'b1;
      repeat (PHASE_ITEMS) run_random_item(plan[ph]);
      wait_settled();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("covered %0d inserts (%0d on a full table), %0d deletes (%0d bad position)",
             sb.n_insert, sb.n_full, sb.n_delete, sb.n_bad_pos);
    $display("plus %0d dedup passes and %0d no-ops; %0d results checked, %0d mismatches",
             sb.n_dedup, sb.n_nop, sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
